FILE: rtl/core/imu_pkg.sv
package imu_pkg;

    localparam int DATA_W = 64;
    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_TRUNC  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_SIGNED = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        WIDTH_8  = 2'd0,
        WIDTH_16 = 2'd1,
        WIDTH_32 = 2'd2,
        WIDTH_64 = 2'd3
    } width_code_t;

    // classified operation handed from front to back
    typedef struct packed {
        logic [DATA_W-1:0] mag_a;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] b_ext;
        logic              neg_a;
        logic              neg_b;
        logic              sgn;
        logic              trunc;
        logic [1:0]        wcode;
        logic              dz;
        logic              last;
    } op_t;

endpackage

FILE: rtl/core/imu_if.sv
interface imu_in_if;
    import imu_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    logic              last_in;
    modport source (output valid, dividend, divisor, last_in, input ready);
    modport sink (input valid, dividend, divisor, last_in, output ready);
endinterface

interface imu_out_if;
    import imu_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] remainder;
    logic              divide_by_zero;
    logic              last_out;
    modport source (output valid, remainder, divide_by_zero, last_out, input ready);
    modport sink (input valid, remainder, divide_by_zero, last_out, output ready);
endinterface

FILE: rtl/core/imu_front.sv
module imu_front
    import imu_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)(
    input  logic        trunc,
    input  logic [1:0]  wcode,
    input  logic        sgn,
    input  logic [DATA_W-1:0] a_raw,
    input  logic [DATA_W-1:0] b_raw,
    input  logic        last,
    output op_t         op
);

    logic [1:0]        wc_eff;
    logic [DATA_W-1:0] a_ext;
    logic [DATA_W-1:0] b_ext;

    function automatic logic [DATA_W-1:0] extend(input logic [DATA_W-1:0] v,
                                                  input logic [1:0] wc,
                                                  input logic s);
        logic [DATA_W-1:0] r;
        begin
            r = v;
            case (width_code_t'(wc))
                WIDTH_8:  r = {{(DATA_W-8){s & v[7]}}, v[7:0]};
                WIDTH_16: r = {{(DATA_W-16){s & v[15]}}, v[15:0]};
                WIDTH_32: r = {{(DATA_W-32){s & v[31]}}, v[31:0]};
                default:  r = v;
            endcase
            return r;
        end
    endfunction

    // clamp width to MAX_WIDTH
    always_comb
    begin
        wc_eff = wcode;
        if (MAX_WIDTH < 16)
            wc_eff = WIDTH_8;
        else if (MAX_WIDTH < 32 && wcode > WIDTH_16)
            wc_eff = WIDTH_16;
        else if (MAX_WIDTH < 64 && wcode > WIDTH_32)
            wc_eff = WIDTH_32;
    end

    assign a_ext = extend(a_raw, wc_eff, sgn);
    assign b_ext = extend(b_raw, wc_eff, sgn);

    always_comb
    begin
        op.neg_a = sgn & a_ext[DATA_W-1];
        op.neg_b = sgn & b_ext[DATA_W-1];
        op.mag_a = op.neg_a ? (DATA_W'(0) - a_ext) : a_ext;
        op.mag_b = op.neg_b ? (DATA_W'(0) - b_ext) : b_ext;
        op.b_ext = b_ext;
        op.sgn   = sgn;
        op.trunc = trunc;
        op.wcode = wc_eff;
        op.dz    = (b_ext == '0);
        op.last  = last;
    end

endmodule

FILE: rtl/core/imu_fifo.sv
module imu_fifo
    import imu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  op_t  wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output op_t  rd_data
);

    op_t        mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_wr;
    logic       do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr    = wr_valid & wr_ready;
    assign do_rd    = rd_valid & rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= ~wptr_reg;
            if (do_rd)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
        end
    end

endmodule

FILE: rtl/core/imu_back.sv
module imu_back
    import imu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  op_t               in_op,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_rem,
    output logic              out_dz,
    output logic              out_last
);

    // one restoring step per stage: a load stage, DATA_W step stages, then the output register with the sign fixup
    localparam int NST = DATA_W;

    typedef struct packed {
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
        logic [DATA_W-1:0] mag_b;
        logic [DATA_W-1:0] b_ext;
        logic              neg_a;
        logic              neg_b;
        logic              sgn;
        logic              trunc;
        logic [1:0]        wcode;
        logic              dz;
        logic              last;
    } st_t;

    st_t  st_reg    [NST+1];
    logic vld_reg   [NST+1];
    st_t  st_next   [NST+1];
    logic adv       [NST+2];
    logic [DATA_W-1:0] fix_r;
    logic [DATA_W-1:0] fix_t;
    logic [DATA_W-1:0] res_reg;
    logic              dz_reg;
    logic              last_reg;
    logic              ov_reg;

    // stage k may move when the next one is empty or moving
    always_comb
    begin
        adv[NST+1] = ~ov_reg | out_ready;
        for (int k = NST; k >= 0; k--)
            adv[k] = ~vld_reg[k] | adv[k+1];
    end

    assign in_ready = adv[0];

    always_comb
    begin
        st_next[0]       = '0;
        st_next[0].quo   = in_op.mag_a;
        st_next[0].mag_b = in_op.mag_b;
        st_next[0].b_ext = in_op.b_ext;
        st_next[0].neg_a = in_op.neg_a;
        st_next[0].neg_b = in_op.neg_b;
        st_next[0].sgn   = in_op.sgn;
        st_next[0].trunc = in_op.trunc;
        st_next[0].wcode = in_op.wcode;
        st_next[0].dz    = in_op.dz;
        st_next[0].last  = in_op.last;
    end

    for (genvar k = 1; k <= NST; k++) begin : g_step
        logic [DATA_W:0] sh;
        logic [DATA_W:0] df;
        always_comb
        begin
            st_next[k] = st_reg[k-1];
            sh = {st_reg[k-1].rem, st_reg[k-1].quo[DATA_W-1]};
            df = sh - {1'b0, st_reg[k-1].mag_b};
            st_next[k].quo = {st_reg[k-1].quo[DATA_W-2:0], ~df[DATA_W]};
            st_next[k].rem = df[DATA_W] ? sh[DATA_W-1:0] : df[DATA_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NST; k++)
                vld_reg[k] <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= adv[0] ? in_valid : vld_reg[0];
            for (int k = 1; k <= NST; k++)
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            if (adv[NST+1])
                ov_reg <= vld_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && in_valid)
            st_reg[0] <= st_next[0];
        for (int k = 1; k <= NST; k++)
            if (adv[k] && vld_reg[k-1])
                st_reg[k] <= st_next[k];
        if (adv[NST+1] && vld_reg[NST])
        begin
            res_reg  <= fix_t;
            dz_reg   <= st_reg[NST].dz;
            last_reg <= st_reg[NST].last;
        end
    end

    // sign fixup, floored correction unless truncated, width wrap, and a zero result on divide by zero
    always_comb
    begin
        fix_r = st_reg[NST].rem;
        fix_t = st_reg[NST].neg_a ? (DATA_W'(0) - fix_r) : fix_r;
        if (!st_reg[NST].trunc && fix_r != '0 && st_reg[NST].neg_a != st_reg[NST].neg_b)
            fix_t = fix_t + st_reg[NST].b_ext;
        if (st_reg[NST].sgn)
        begin
            case (width_code_t'(st_reg[NST].wcode))
                WIDTH_8:  fix_t = {{(DATA_W-8){fix_t[7]}}, fix_t[7:0]};
                WIDTH_16: fix_t = {{(DATA_W-16){fix_t[15]}}, fix_t[15:0]};
                WIDTH_32: fix_t = {{(DATA_W-32){fix_t[31]}}, fix_t[31:0]};
                default:  fix_t = fix_t;
            endcase
        end
        if (st_reg[NST].dz)
            fix_t = '0;
    end

    assign out_valid = ov_reg;
    assign out_rem   = res_reg;
    assign out_dz    = dz_reg;
    assign out_last  = last_reg;

endmodule

FILE: rtl/core/integer_modulo_unit_core.sv
// throughput: one transaction per cycle when the output is not stalled, set by a 64-stage restoring divider
// with one quotient bit per stage, a load stage and the sign fixup folded into the output register
// a two-entry queue between classifier and divider absorbs output stalls
// reset (rst_n low, asynchronous) empties the pipeline and queue and sets
// truncated_mode 0, width_code 2 (32 bits), signed_elements 1
module integer_modulo_unit_core
    import imu_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)(
    input  logic               clk,
    input  logic               rst_n,
    imu_in_if.sink             in_ch,
    imu_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       trunc_reg;
    logic [1:0] width_reg;
    logic       signed_reg;
    logic [1:0] idx;
    op_t        f_op;
    op_t        q_op;
    logic       q_valid;
    logic       q_ready;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trunc_reg  <= 1'b0;
            width_reg  <= WIDTH_32;
            signed_reg <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx_t'(idx))
                REG_TRUNC:  trunc_reg  <= pwdata[0];
                REG_WIDTH:  width_reg  <= pwdata[1:0];
                REG_SIGNED: signed_reg <= pwdata[0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(idx))
            REG_TRUNC:  prdata = {31'd0, trunc_reg};
            REG_WIDTH:  prdata = {30'd0, width_reg};
            REG_SIGNED: prdata = {31'd0, signed_reg};
            default:    prdata = 32'd0;
        endcase
    end

    imu_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .trunc (trunc_reg),
        .wcode (width_reg),
        .sgn   (signed_reg),
        .a_raw (in_ch.dividend),
        .b_raw (in_ch.divisor),
        .last  (in_ch.last_in),
        .op    (f_op)
    );

    imu_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_ch.valid),
        .wr_ready (in_ch.ready),
        .wr_data  (f_op),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_op)
    );

    imu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .in_ready  (q_ready),
        .in_op     (q_op),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_rem   (out_ch.remainder),
        .out_dz    (out_ch.divide_by_zero),
        .out_last  (out_ch.last_out)
    );

endmodule

FILE: rtl/core/imu_checker.sv
module imu_checker
    import imu_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DATA_W-1:0] remainder,
    input logic              divide_by_zero,
    input logic              psel,
    input logic              penable,
    input logic              pready
);

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> remainder == '0)
        else $error("divide by zero with nonzero remainder");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(remainder))
        else $error("result dropped under stall");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable |-> pready)
        else $error("apb access stalled");

endmodule

bind integer_modulo_unit_core imu_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .remainder      (out_ch.remainder),
    .divide_by_zero (out_ch.divide_by_zero),
    .psel           (psel),
    .penable        (penable),
    .pready         (pready)
);

FILE: sim/tb_integer_modulo_unit_core.sv
`timescale 1ns / 1ps

class remainder_scoreboard;
    typedef struct packed {
        logic [63:0] remainder;
        logic        divide_by_zero;
        logic        last_out;
    } rem_result_t;

    bit          trunc_mode;
    bit [1:0]    wcode;
    bit          sgn;
    rem_result_t pending[$];
    int          errors;

    function new();
        trunc_mode = 1'b0;
        wcode      = 2'd2;
        sgn        = 1'b1;
        errors     = 0;
    endfunction

    function logic [63:0] elem_mask();
        logic [63:0] m;
        case (wcode)
            imu_pkg::WIDTH_8:  m = 64'hff;
            imu_pkg::WIDTH_16: m = 64'hffff;
            imu_pkg::WIDTH_32: m = 64'hffff_ffff;
            default:           m = '1;
        endcase
        return m;
    endfunction

    function logic [63:0] widen(logic [63:0] v, bit s);
        logic [63:0] m;
        logic [63:0] top;
        m = elem_mask();
        top = (m >> 1) + 64'd1;
        v = v & m;
        if (s && (v & top) != 0)
            v = v | ~m;
        return v;
    endfunction

    function void note_operands(logic [63:0] a_raw, logic [63:0] b_raw, logic last);
        rem_result_t r;
        logic [63:0] a, b, ma, mb, rm, t;
        logic        na, nb;
        a = widen(a_raw, sgn);
        b = widen(b_raw, sgn);
        r.remainder = '0;
        r.divide_by_zero = 1'b0;
        r.last_out = last;
        if (b == 0) begin
            r.divide_by_zero = 1'b1;
        end else if (!sgn) begin
            r.remainder = a % b;
        end else begin
            na = a[63];
            nb = b[63];
            ma = na ? -a : a;
            mb = nb ? -b : b;
            rm = ma % mb;
            t = na ? -rm : rm;
            if (!trunc_mode && rm != 0 && na != nb)
                t = t + b;
            r.remainder = widen(t, 1'b1);
        end
        pending.push_back(r);
    endfunction

    function void check_result(logic [63:0] rem, logic dz, logic last);
        rem_result_t e;
        if (pending.size() == 0) begin
            $error("unexpected result transaction rem=%h", rem);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (rem !== e.remainder) begin
            $error("remainder expected %h actual %h", e.remainder, rem);
            errors++;
        end
        if (dz !== e.divide_by_zero) begin
            $error("divide_by_zero expected %0b actual %0b", e.divide_by_zero, dz);
            errors++;
        end
        if (last !== e.last_out) begin
            $error("last_out expected %0b actual %0b", e.last_out, last);
            errors++;
        end
    endfunction
endclass

module tb_integer_modulo_unit_core;
    import imu_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 80;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    bit   sink_calm;
    bit   source_calm;
    int   idle_cycles;

    imu_in_if  in_ch();
    imu_out_if out_ch();

    remainder_scoreboard sb;

    integer_modulo_unit_core dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // output side: random backpressure, check on each transaction
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_ch.valid && out_ch.ready)
                sb.check_result(out_ch.remainder, out_ch.divide_by_zero, out_ch.last_out);
            out_ch.ready <= sink_calm ? 1'b1 : ($urandom_range(0, 99) >= 14);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRUNC: sb.trunc_mode = value[0];
            REG_WIDTH: sb.wcode = value[1:0];
            default:   sb.sgn = value[0];
        endcase
    endtask

    // valid stays high on return so transactions can follow back to back
    task automatic send_operands(logic [63:0] a, logic [63:0] b, logic last);
        while (!source_calm && $urandom_range(0, 99) < 14) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.dividend <= a;
        in_ch.divisor  <= b;
        in_ch.last_in  <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_operands(a, b, last);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // small magnitudes and edge values half the time, full random otherwise, so signs and fixups are exercised
    function automatic logic [63:0] pick_operand();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return '0;
            1: return '1;
            2: return 64'h8000_0000_0000_0000 >> (8 * $urandom_range(0, 7));
            3, 4: return {{56{$urandom_range(0, 1) == 1}}, 8'($urandom())};
            default: return rand64();
        endcase
    endfunction

    task automatic run_directed();
        logic [63:0] mn;
        mn = 64'd1 << ((8 << sb.wcode) - 1);
        send_operands(64'd7, 64'd3, 1'b0);
        send_operands(-64'd7, 64'd3, 1'b0);
        send_operands(64'd7, -64'd3, 1'b0);
        send_operands(-64'd7, -64'd3, 1'b0);
        send_operands(-64'd6, 64'd3, 1'b0);
        send_operands(64'd5, 64'd0, 1'b1);
        send_operands(mn, '1, 1'b0);
        send_operands(mn, 64'd1, 1'b0);
        send_operands('1, mn, 1'b0);
        send_operands(mn - 64'd1, mn, 1'b0);
        send_operands('1, '1, 1'b1);
        send_operands(64'hdead_beef_0000_0000, 64'hffff_ffff_0000_0000, 1'b0);
        send_operands('0, 64'd9, 1'b1);
    endtask

    initial
    begin
        int phase;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_ch.valid = 1'b0; in_ch.dividend = '0; in_ch.divisor = '0; in_ch.last_in = 1'b0;
        out_ch.ready = 1'b0;
        sink_calm = 1'b0;
        source_calm = 1'b0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration first, then the directed corners for the first eight settings
        run_directed();
        wait_drained();
        for (phase = 0; phase < 16; phase++) begin
            write_reg(REG_TRUNC, {31'($urandom()), phase[0]});
            write_reg(REG_WIDTH, {30'($urandom()), phase[2:1]});
            write_reg(REG_SIGNED, {31'($urandom()), phase[3]});
            if (phase < 8)
                run_directed();
            source_calm = (phase == 5 || phase == 6);
            sink_calm = (phase == 5 || phase == 6);
            repeat (36) send_operands(pick_operand(), pick_operand(), 1'($urandom()));
            source_calm = 1'b0;
            sink_calm = 1'b0;
            wait_drained();
        end

        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/imu_pkg.sv
rtl/core/imu_if.sv
rtl/core/imu_front.sv
rtl/core/imu_fifo.sv
rtl/core/imu_back.sv
rtl/core/integer_modulo_unit_core.sv
rtl/core/imu_checker.sv
sim/tb_integer_modulo_unit_core.sv
